// ----- rtl/ogre_pkg.sv -----
// ----------------------------------------------------------------------------
// ogre_pkg
// Shared types, field widths and codes for the occupancy grid rectangle engine.
// ----------------------------------------------------------------------------
package ogre_pkg;

  localparam int CFG_W  = 7;
  localparam int POS_W  = 8;
  localparam int SIZE_W = 7;

  typedef logic [CFG_W-1:0]         cfg_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic [SIZE_W-1:0]        dim_t;

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Plane selects.
  localparam logic PLANE_WALK  = 1'b0;
  localparam logic PLANE_PLACE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam cfg_t GRID_RESET = 7'd64;

endpackage

// ----- rtl/occupancy_grid_rect_engine_top.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_rect_engine_top
// Two one-bit occupancy planes kept one grid row per RAM word; rectangle
// writes and queries run as a read-modify-write sweep over the covered rows.
// ----------------------------------------------------------------------------
// Sequence: an item is transferred in S_IDLE, its rows are read in S_RUN,
// the last row returns in S_DRAIN and the result is registered in S_FINISH;
// a zero-height or out-of-bounds rectangle goes from S_IDLE to S_FINISH. The
// RAM read port delivers one row per cycle and an item starts only after the
// previous one has retired.
// Reset: both planes are set to all ones by a clearing pass over every RAM
// word, with in_ready low.
// ----------------------------------------------------------------------------
module occupancy_grid_rect_engine_top import ogre_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic clk,
  input  logic rst,
  // Configuration write channel.
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  cfg_t cfg_data,
  // Item input channel.
  input  logic in_valid,
  output logic in_ready,
  input  logic cmd,
  input  logic plane,
  input  pos_t pos_x,
  input  pos_t pos_y,
  input  dim_t size_x,
  input  dim_t size_y,
  input  logic fill_value,
  // Result output channel.
  output logic out_valid,
  input  logic out_ready,
  output logic in_bounds,
  output logic answer
);

  // The RAM address is the plane bit followed by the row number, so both
  // planes share one memory.
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = RW + 1;
  localparam int DEPTH = 2 ** AW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers. The port never stalls.
  cfg_t grid_width;
  cfg_t grid_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bounds test and column mask are worked out from the input ports, so they
  // are ready in the cycle the item is transferred.
  logic                 inb_w;
  logic [MAX_WIDTH-1:0] mask_w;
  logic [RW-1:0]        row_start_w;

  ogre_bounds #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_bounds (
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .size_x      (size_x),
    .size_y      (size_y),
    .inb         (inb_w),
    .mask        (mask_w),
    .row_start   (row_start_w)
  );

  // Operation registers, loaded on the input transfer.
  logic                 op_cmd;
  logic                 op_plane;
  logic                 op_fill;
  logic                 op_inb;
  logic [MAX_WIDTH-1:0] op_mask;
  logic [RW-1:0]        row;
  dim_t                 rows_left;
  logic                 all_ok;

  // Read pipeline: the read issued in one cycle returns data in the next,
  // where the modified row is written back to the same address. Rows within
  // one item are distinct, and a new item only starts reading once the last
  // write-back of the previous one has landed, so no forwarding is needed.
  logic                 pend_valid;
  logic [AW-1:0]        pend_addr;
  logic [AW-1:0]        clr_addr;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [MAX_WIDTH-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [MAX_WIDTH-1:0] wr_data;
  logic                 row_ok;
  logic                 accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign rd_en   = (state == S_RUN);
  assign rd_addr = {op_plane, row};

  // A query row passes when every masked cell is set.
  assign row_ok = &(rd_data | ~op_mask);

  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '1;
    end else begin
      wr_en   = pend_valid && (op_cmd == CMD_WRITE);
      wr_addr = pend_addr;
      wr_data = (rd_data & ~op_mask) | (op_fill ? op_mask : '0);
    end
  end

  ogre_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: clearing pass after reset, then one item at a time. The
  // result register lets the next item be transferred while the previous
  // result still waits for its output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend_valid <= (state == S_RUN);
      pend_addr  <= rd_addr;

      // A result leaves at its output transfer, unless the finishing item
      // puts a new one in its place in the same cycle.
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      if (pend_valid && (op_cmd == CMD_QUERY)) begin
        all_ok <= all_ok & row_ok;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_cmd    <= cmd;
            op_plane  <= plane;
            op_fill   <= fill_value;
            op_inb    <= inb_w;
            op_mask   <= mask_w;
            row       <= row_start_w;
            rows_left <= size_y;
            all_ok    <= 1'b1;
            // Out-of-bounds and zero-height rectangles touch no row.
            if (inb_w && (size_y != '0)) begin
              state <= S_RUN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_RUN: begin
          row       <= row + RW'(1);
          rows_left <= rows_left - SIZE_W'(1);
          if (rows_left == SIZE_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // The last row's data returns and is written back or checked here.
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            in_bounds <= op_inb;
            answer    <= (op_cmd == CMD_WRITE) ? op_inb : (op_inb & all_ok);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ogre_ram.sv -----
// ----------------------------------------------------------------------------
// ogre_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ogre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/ogre_bounds.sv -----
// ----------------------------------------------------------------------------
// ogre_bounds
// Bounds test of a rectangle against the grid size, and its column mask.
// ----------------------------------------------------------------------------
module ogre_bounds import ogre_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  cfg_t                            grid_width,
  input  cfg_t                            grid_height,
  input  pos_t                            pos_x,
  input  pos_t                            pos_y,
  input  dim_t                            size_x,
  input  dim_t                            size_y,
  output logic                            inb,
  output logic [MAX_WIDTH-1:0]            mask,
  output logic [$clog2(MAX_HEIGHT)-1:0]   row_start
);

  // Compare widths hold the grid limit and a corner plus a size.
  localparam int XW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
  localparam int YW = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [XW-1:0] gw_ext, eff_w, px, sx, x_end;
  logic [YW-1:0] gh_ext, eff_h, py, sy, y_end;

  always_comb begin
    gw_ext = XW'(grid_width);
    gh_ext = YW'(grid_height);
    eff_w  = (gw_ext < XW'(MAX_WIDTH)) ? gw_ext : XW'(MAX_WIDTH);
    eff_h  = (gh_ext < YW'(MAX_HEIGHT)) ? gh_ext : YW'(MAX_HEIGHT);
    // Only used when the sign bits are clear, so plain zero extension.
    px     = XW'(unsigned'(pos_x));
    py     = YW'(unsigned'(pos_y));
    sx     = XW'(size_x);
    sy     = YW'(size_y);
    x_end  = px + sx;
    y_end  = py + sy;
    inb    = !pos_x[POS_W-1] && !pos_y[POS_W-1] &&
             (px < eff_w) && (py < eff_h) &&
             (x_end <= eff_w) && (y_end <= eff_h);
    row_start = py[RW-1:0];
  end

  // One bit per column: set where the column falls inside [pos_x, pos_x + size_x).
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = (XW'(i) >= px) && (XW'(i) < x_end);
    end
  end

endmodule

// ----- rtl/ogre_checker.sv -----
// ----------------------------------------------------------------------------
// ogre_checker
// Port-level checks for the occupancy grid rectangle engine, bound to the top.
// ----------------------------------------------------------------------------
module ogre_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic in_bounds,
  input logic answer
);

  // Reset starts the clearing pass: no item is taken and no result is shown.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("item channel active right after reset");

  // An out-of-bounds rectangle can never answer true.
  a_oob_false: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_bounds |-> !answer)
    else $error("answer set on an out-of-bounds rectangle");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(in_bounds) && $stable(answer))
    else $error("result changed or dropped while stalled");

  // Items are handled one at a time, so the input closes after each transfer.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready still high after an input transfer");

endmodule

bind occupancy_grid_rect_engine_top ogre_checker u_ogre_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .in_bounds (in_bounds),
  .answer    (answer)
);

// ----- dv/occupancy_grid_rect_engine_top_test.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_rect_engine_top_test
// Self-checking bench for the rectangle engine. A local model of both planes
// predicts in_bounds and answer for every input transfer; results are checked
// in order under random input gaps, output stalls and grid resizing.
// ----------------------------------------------------------------------------
module occupancy_grid_rect_engine_top_test import ogre_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W          = 64;
  localparam int MAX_H          = 64;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 140;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic op;
    logic plane_sel;
    pos_t x;
    pos_t y;
    dim_t w;
    dim_t h;
    logic fill;
  } rect_item_t;

  typedef struct {
    logic in_bounds;
    logic answer;
  } rect_result_t;

  // Clock, reset and DUT ports. Every input starts at a known value.
  logic clk        = 1'b0;
  logic rst        = 1'b1;
  logic cfg_valid  = 1'b0;
  logic cfg_ready;
  logic cfg_index  = REG_GRID_WIDTH;
  cfg_t cfg_data   = '0;
  logic in_valid   = 1'b0;
  logic in_ready;
  logic cmd        = CMD_WRITE;
  logic plane      = PLANE_WALK;
  pos_t pos_x      = '0;
  pos_t pos_y      = '0;
  dim_t size_x     = '0;
  dim_t size_y     = '0;
  logic fill_value = 1'b0;
  logic out_valid;
  logic out_ready  = 1'b0;
  logic in_bounds;
  logic answer;

  // Local copy of the grid: one 64-bit word per row, as after reset.
  logic [MAX_W-1:0] walk_rows  [MAX_H];
  logic [MAX_W-1:0] place_rows [MAX_H];
  cfg_t grid_w = GRID_RESET;
  cfg_t grid_h = GRID_RESET;

  // Results predicted for accepted items, oldest first.
  rect_result_t pending_results [$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  // Idling switches for the sender and the receiver, and the request for one
  // long receiver hold-off.
  bit  in_idle_on     = 1'b1;
  bit  out_idle_on    = 1'b1;
  bit  hold_req       = 1'b0;

  occupancy_grid_rect_engine_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .plane      (plane),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .size_x     (size_x),
    .size_y     (size_y),
    .fill_value (fill_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .in_bounds  (in_bounds),
    .answer     (answer)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int r = 0; r < MAX_H; r++) begin
      walk_rows[r]  = '1;
      place_rows[r] = '1;
    end
  end

  // The effective grid size saturates at the physical size of the planes.
  function automatic int eff_w();
    return (int'(grid_w) < MAX_W) ? int'(grid_w) : MAX_W;
  endfunction

  function automatic int eff_h();
    return (int'(grid_h) < MAX_H) ? int'(grid_h) : MAX_H;
  endfunction

  // Applies one rectangle to the local planes and returns the result that
  // the engine must give for it. Out-of-bounds writes leave the planes alone.
  function automatic rect_result_t apply_rect(rect_item_t it);
    rect_result_t res;
    int           px;
    int           py;
    int           sx;
    int           sy;
    int           gw;
    int           gh;
    logic         hit;
    logic         all_set;
    px = int'(it.x);
    py = int'(it.y);
    sx = int'(it.w);
    sy = int'(it.h);
    gw = eff_w();
    gh = eff_h();
    hit = (px >= 0) && (px < gw) && (py >= 0) && (py < gh) &&
          (px + sx <= gw) && (py + sy <= gh);
    all_set = hit;
    if (hit) begin
      for (int r = py; r < py + sy; r++) begin
        for (int c = px; c < px + sx; c++) begin
          if (it.op == CMD_WRITE) begin
            if (it.plane_sel == PLANE_PLACE) begin
              place_rows[r][c] = it.fill;
            end else begin
              walk_rows[r][c] = it.fill;
            end
          end else if (it.plane_sel == PLANE_PLACE) begin
            if (!place_rows[r][c]) all_set = 1'b0;
          end else begin
            if (!walk_rows[r][c]) all_set = 1'b0;
          end
        end
      end
    end
    res.in_bounds = hit;
    res.answer    = (it.op == CMD_WRITE) ? hit : all_set;
    return res;
  endfunction

  // Appends one prediction at the young end of the queue.
  task automatic store_prediction(input rect_result_t res);
    pending_results = {pending_results, res};
  endtask

  function automatic rect_item_t rect(logic op, logic plane_sel, int px, int py,
                                      int sx, int sy, logic fill);
    rect_item_t it;
    it.op        = op;
    it.plane_sel = plane_sel;
    it.x         = pos_t'(px);
    it.y         = pos_t'(py);
    it.w         = dim_t'(sx);
    it.h         = dim_t'(sy);
    it.fill      = fill;
    return it;
  endfunction

  // Random rectangle for a gw x gh grid. Most items land inside the grid with
  // few rows, so the planes get real traffic at a sensible rate; the rest
  // probe the edges, negative corners and raw encodings.
  function automatic rect_item_t random_rect(int gw, int gh);
    rect_item_t it;
    int         kind;
    int         px;
    int         py;
    int         sx;
    int         sy;
    int         room;
    kind = $urandom_range(0, 9);
    if (kind < 7 && gw > 0 && gh > 0) begin
      px = $urandom_range(0, gw - 1);
      py = $urandom_range(0, gh - 1);
      room = gw - px;
      if ($urandom_range(0, 9) == 0) begin
        sx = $urandom_range(0, room);
      end else begin
        sx = $urandom_range(0, (room < 6) ? room : 6);
      end
      room = gh - py;
      if ($urandom_range(0, 19) == 0) begin
        sy = $urandom_range(0, room);
      end else begin
        sy = $urandom_range(0, (room < 4) ? room : 4);
      end
    end else if (kind == 7) begin
      // Straddle the far corner of the grid.
      px = gw - $urandom_range(0, 2);
      py = gh - $urandom_range(0, 2);
      sx = $urandom_range(0, 3);
      sy = $urandom_range(0, 3);
    end else if (kind == 8) begin
      px = $urandom_range(0, 255);
      py = $urandom_range(0, 255);
      sx = $urandom_range(0, 127);
      sy = $urandom_range(0, 127);
    end else begin
      px = $urandom_range(0, 3);
      py = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) begin
        px = -int'($urandom_range(1, 128));
      end else begin
        py = -int'($urandom_range(1, 128));
      end
      sx = $urandom_range(0, 4);
      sy = $urandom_range(0, 4);
    end
    it = rect(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), px, py, sx, sy,
              $urandom_range(0, 9) < 7);
    return it;
  endfunction

  // Offers one item and waits for its transfer. Valid stays high between
  // back-to-back items; a gap lowers it for a random burst first.
  task automatic send_rect(input rect_item_t it);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= it.op;
    plane      <= it.plane_sel;
    pos_x      <= it.x;
    pos_y      <= it.y;
    size_x     <= it.w;
    size_y     <= it.h;
    fill_value <= it.fill;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    store_prediction(apply_rect(it));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_rect(random_rect(eff_w(), eff_h()));
  endtask

  // Stops offering items and waits until every predicted result has arrived.
  // Every item yields a result, so an empty queue means the engine is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes both grid registers back to back while the engine is idle.
  task automatic configure_grid(input int w, input int h);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= cfg_t'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grid_w = cfg_t'(w);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= cfg_t'(h);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grid_h = cfg_t'(h);
    cfg_valid <= 1'b0;
  endtask

  // Result side: ready idles in random bursts, or holds off for one long
  // stretch on request so that the engine backs up into its input.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    rect_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: in_bounds %0b answer %0b", in_bounds, answer);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (in_bounds !== exp_res.in_bounds) begin
          $error("in_bounds mismatch: expected %0b, actual %0b",
                 exp_res.in_bounds, in_bounds);
          mismatch_count++;
        end
        if (answer !== exp_res.answer) begin
          $error("answer mismatch: expected %0b, actual %0b", exp_res.answer, answer);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transfer happens on any channel. The
  // limit covers the clearing pass after reset, the tallest rectangle and the
  // long receiver hold-off with room to spare.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Field extremes and the special cases on the reset-size grid. The first
  // queries also confirm that both planes come out of reset all ones.
  task automatic test_directed_extremes();
    send_rect(rect(CMD_QUERY, PLANE_WALK,   0,   0,  64,  64, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_PLACE,  0,   0,  64,  64, 1'b0));
    send_rect(rect(CMD_WRITE, PLANE_WALK,   0,   0,   1,   1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK,   0,   0,   1,   1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_PLACE,  0,   0,   1,   1, 1'b0));
    send_rect(rect(CMD_WRITE, PLANE_PLACE, 63,  63,   1,   1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_PLACE,  0,   0,  64,  64, 1'b1));
    send_rect(rect(CMD_QUERY, PLANE_PLACE, 63,  63,   1,   1, 1'b1));
    // Empty rectangles: in bounds only while the corner is inside.
    send_rect(rect(CMD_QUERY, PLANE_WALK,   5,   5,   0,   0, 1'b0));
    send_rect(rect(CMD_WRITE, PLANE_WALK,   7,   7,   0,   9, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK,   7,   7,   1,   9, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK,  64,   0,   0,   0, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK,   0,  63,   0,   0, 1'b0));
    // Negative corners and the ends of the position encoding.
    send_rect(rect(CMD_QUERY, PLANE_WALK,  -1,   0,   1,   1, 1'b0));
    send_rect(rect(CMD_WRITE, PLANE_WALK,   0, -128,  1,   1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK, 127, 127,   1,   1, 1'b1));
    // Sizes beyond the grid; an out-of-bounds write must not touch cells.
    send_rect(rect(CMD_QUERY, PLANE_WALK,   0,   0, 127, 127, 1'b1));
    send_rect(rect(CMD_WRITE, PLANE_WALK,  60,   0,   5,   1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK,  60,   0,   4,   1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK,   0,   0,  65,   1, 1'b0));
    // Full-grid writes restore both planes.
    send_rect(rect(CMD_WRITE, PLANE_WALK,   0,   0,  64,  64, 1'b1));
    send_rect(rect(CMD_WRITE, PLANE_PLACE,  0,   0,  64,  64, 1'b1));
    send_rect(rect(CMD_QUERY, PLANE_WALK,   0,   0,  64,  64, 1'b0));
  endtask

  // Grid size extremes. Cells outside a shrunken grid must keep their values
  // and show up again once the grid grows back.
  task automatic test_grid_resize();
    send_rect(rect(CMD_WRITE, PLANE_WALK,  40, 40, 1, 1, 1'b0));
    send_rect(rect(CMD_WRITE, PLANE_PLACE, 50, 20, 2, 2, 1'b0));
    configure_grid(16, 16);
    send_rect(rect(CMD_QUERY, PLANE_WALK,  40, 40, 1, 1, 1'b0));
    send_rect(rect(CMD_WRITE, PLANE_WALK,  40, 40, 1, 1, 1'b1));
    send_rect(rect(CMD_QUERY, PLANE_WALK,  15, 15, 1, 1, 1'b0));
    send_random(25);
    // A zero width leaves nothing in bounds, not even an empty rectangle.
    configure_grid(0, 127);
    send_rect(rect(CMD_QUERY, PLANE_WALK,   0,  0, 0, 0, 1'b0));
    send_rect(rect(CMD_WRITE, PLANE_PLACE,  0,  0, 1, 1, 1'b0));
    send_random(6);
    configure_grid(127, 0);
    send_rect(rect(CMD_QUERY, PLANE_PLACE,  0,  0, 0, 0, 1'b0));
    send_random(6);
    configure_grid(1, 1);
    send_rect(rect(CMD_WRITE, PLANE_WALK,   0,  0, 1, 1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK,   0,  0, 1, 1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK,   0,  0, 1, 2, 1'b0));
    send_random(6);
    // Oversized registers saturate at the plane size.
    configure_grid(127, 127);
    send_rect(rect(CMD_QUERY, PLANE_WALK,  63, 63, 1, 1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_WALK,  64,  0, 1, 1, 1'b0));
    send_rect(rect(CMD_QUERY, PLANE_PLACE, 50, 20, 2, 2, 1'b0));
    send_random(8);
    configure_grid(2, 2);
    send_random(15);
    configure_grid(64, 64);
    send_rect(rect(CMD_QUERY, PLANE_WALK,  40, 40, 1, 1, 1'b0));
    send_rect(rect(CMD_WRITE, PLANE_WALK,  40, 40, 1, 1, 1'b1));
    send_rect(rect(CMD_QUERY, PLANE_PLACE, 50, 20, 2, 2, 1'b0));
  endtask

  // Random phases on random grids, mostly nominal sizes with a share of
  // tiny grids and of out-of-range register values.
  task automatic test_random_traffic();
    int dims [2];
    for (int p = 0; p < 8; p++) begin
      for (int d = 0; d < 2; d++) begin
        case ($urandom_range(0, 7))
          5: begin
            dims[d] = $urandom_range(2, 8);
          end
          6: begin
            dims[d] = $urandom_range(65, 127);
          end
          7: begin
            dims[d] = $urandom_range(0, 1);
          end
          default: begin
            dims[d] = $urandom_range(2, 64);
          end
        endcase
      end
      if (p == 0) begin
        dims[0] = $urandom_range(2, 8);
        dims[1] = $urandom_range(2, 8);
      end
      configure_grid(dims[0], dims[1]);
      send_random(140);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering items, so the engine fills and must stall its input.
  task automatic test_output_backpressure();
    configure_grid(32, 24);
    in_idle_on = 1'b0;
    hold_req   = 1'b1;
    send_random(40);
    in_idle_on = 1'b1;
  endtask

  // Last part of the run with no idling on either side.
  task automatic test_back_to_back();
    configure_grid(64, 64);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    send_random(200);
  endtask

  initial begin : main
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_grid_resize();
    test_random_traffic();
    test_output_backpressure();
    test_back_to_back();
    drain_results();
    // Any result arriving now has no prediction and is flagged by the result comparison.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ogre_pkg.sv
rtl/ogre_ram.sv
rtl/ogre_bounds.sv
rtl/occupancy_grid_rect_engine_top.sv
rtl/ogre_checker.sv
dv/occupancy_grid_rect_engine_top_test.sv
